@@ src/fct_pkg.sv @@
package fct_pkg;

    // Kind of an input item, carried in the low bits of s_tuser.
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_POINT  = 2'd1,
        OP_SPHERE = 2'd2,
        OP_BOX    = 2'd3
    } opcode_t;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    // Axis codes used by the operand selector of the multiply unit.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Fraction bits of the Q16.16 format.
    localparam int FRAC_BITS = 16;

    // Per plane: six partial products issued in steps 0 to 5, decision in step 6.
    localparam int          STEP_W    = 3;
    localparam logic [2:0]  LAST_STEP = 3'd6;

    // Field widths fixed by the stream format.
    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 3;
    localparam int USER_W   = OPCODE_W + INDEX_W;
    localparam int FAIL_W   = 3;
    localparam int OUT_W    = 8;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic       capture;    // latch the accepted test item
        logic       load_bias;  // start a plane: accumulator takes the scaled bias
        logic       acc_en;     // add the registered partial product
        logic       mul_en;     // issue a partial product
        logic [1:0] axis;       // which normal component and coordinate
        logic       hi_half;    // upper half of the normal component
    } fct_mac_ctrl_t;

endpackage

@@ src/fct_plane_store.sv @@
module fct_plane_store import fct_pkg::*; #(
    parameter int NUM_PLANES = 6,
    parameter int COORD_BITS = 32,
    parameter int PIDX_W     = 3
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [PIDX_W-1:0]            wr_addr,
    input  logic signed [COORD_BITS-1:0] wr_nx,
    input  logic signed [COORD_BITS-1:0] wr_ny,
    input  logic signed [COORD_BITS-1:0] wr_nz,
    input  logic signed [COORD_BITS-1:0] wr_offset,
    input  logic [PIDX_W-1:0]            rd_addr,
    output logic signed [COORD_BITS-1:0] rd_nx,
    output logic signed [COORD_BITS-1:0] rd_ny,
    output logic signed [COORD_BITS-1:0] rd_nz,
    output logic signed [COORD_BITS-1:0] rd_offset
);

    logic signed [COORD_BITS-1:0] nx_reg     [NUM_PLANES];
    logic signed [COORD_BITS-1:0] ny_reg     [NUM_PLANES];
    logic signed [COORD_BITS-1:0] nz_reg     [NUM_PLANES];
    logic signed [COORD_BITS-1:0] offset_reg [NUM_PLANES];

    // Plane writes; the entries hold nothing defined until written.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            nx_reg[wr_addr]     <= wr_nx;
            ny_reg[wr_addr]     <= wr_ny;
            nz_reg[wr_addr]     <= wr_nz;
            offset_reg[wr_addr] <= wr_offset;
        end
    end

    // The plane under test is selected by the sequencer's plane counter.
    assign rd_nx     = nx_reg[rd_addr];
    assign rd_ny     = ny_reg[rd_addr];
    assign rd_nz     = nz_reg[rd_addr];
    assign rd_offset = offset_reg[rd_addr];

endmodule

@@ src/fct_mac.sv @@
module fct_mac import fct_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  logic                         aclk,
    input  fct_mac_ctrl_t                ctrl,
    input  opcode_t                      in_opcode,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic signed [COORD_BITS-1:0] in_z,
    input  logic signed [COORD_BITS-1:0] in_far_x,
    input  logic signed [COORD_BITS-1:0] in_far_y,
    input  logic signed [COORD_BITS-1:0] in_far_z,
    input  logic signed [COORD_BITS-1:0] in_scalar,
    input  logic signed [COORD_BITS-1:0] nx,
    input  logic signed [COORD_BITS-1:0] ny,
    input  logic signed [COORD_BITS-1:0] nz,
    input  logic signed [COORD_BITS-1:0] offset,
    output logic                         negative
);

    // The normal component is split into an unsigned low half and a signed high half.
    localparam int LO    = COORD_BITS / 2;
    localparam int MA    = LO + 1;
    localparam int P_W   = MA + COORD_BITS;
    // Exact width of n.p + bias * 2^16; intermediate wrap-around cancels out.
    localparam int ACC_W = 2 * COORD_BITS + 2;

    logic signed [COORD_BITS-1:0] x_reg, y_reg, z_reg;
    logic signed [COORD_BITS-1:0] far_x_reg, far_y_reg, far_z_reg;
    logic signed [COORD_BITS-1:0] scalar_reg;
    logic                         box_reg, sphere_reg;
    logic signed [P_W-1:0]        prod_reg;
    logic                         hi_reg;
    logic signed [ACC_W-1:0]      acc_reg;

    logic signed [COORD_BITS-1:0] n_sel, c_min, c_far, c_sel, radius;
    logic                         n_positive;
    logic signed [MA-1:0]         mul_a;
    logic signed [P_W-1:0]        prod_full;
    logic signed [COORD_BITS:0]   bias;
    logic signed [ACC_W-1:0]      bias_acc, term_ext, term, sum;

    // Operand selection for the current axis.
    always_comb begin
        unique case (ctrl.axis)
            AXIS_X: begin
                n_sel = nx;
                c_min = x_reg;
                c_far = far_x_reg;
            end
            AXIS_Y: begin
                n_sel = ny;
                c_min = y_reg;
                c_far = far_y_reg;
            end
            AXIS_Z: begin
                n_sel = nz;
                c_min = z_reg;
                c_far = far_z_reg;
            end
            default: begin
                n_sel = '0;
                c_min = '0;
                c_far = '0;
            end
        endcase
    end

    // A box is tested at its positive vertex: the maximum where the normal is above zero.
    assign n_positive = !n_sel[COORD_BITS-1] && (n_sel != '0);
    assign c_sel      = (box_reg && n_positive) ? c_far : c_min;

    // Shared multiplier: one half of the normal component times the coordinate.
    assign mul_a     = ctrl.hi_half ? MA'($signed(n_sel[COORD_BITS-1:LO]))
                                    : $signed({1'b0, n_sel[LO-1:0]});
    assign prod_full = mul_a * c_sel;

    // Plane bias is the offset, plus the radius for a sphere, scaled to Q32.32.
    assign radius   = sphere_reg ? scalar_reg : '0;
    assign bias     = (COORD_BITS + 1)'(offset) + (COORD_BITS + 1)'(radius);
    assign bias_acc = ACC_W'(bias) <<< FRAC_BITS;

    // Partial product aligned to its weight, then added to the running sum.
    assign term_ext = ACC_W'(prod_reg);
    assign term     = hi_reg ? (term_ext <<< LO) : term_ext;
    assign sum      = acc_reg + term;
    assign negative = sum[ACC_W-1];

    // Item capture, product register and accumulator.
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            x_reg      <= in_x;
            y_reg      <= in_y;
            z_reg      <= in_z;
            far_x_reg  <= in_far_x;
            far_y_reg  <= in_far_y;
            far_z_reg  <= in_far_z;
            scalar_reg <= in_scalar;
            box_reg    <= (in_opcode == OP_BOX);
            sphere_reg <= (in_opcode == OP_SPHERE);
        end
        if (ctrl.mul_en) begin
            prod_reg <= prod_full;
            hi_reg   <= ctrl.hi_half;
        end
        if (ctrl.load_bias) begin
            acc_reg <= bias_acc;
        end else if (ctrl.acc_en) begin
            acc_reg <= sum;
        end
    end

endmodule

@@ src/fct_seq.sv @@
module fct_seq import fct_pkg::*; #(
    parameter int NUM_PLANES = 6,
    parameter int PIDX_W     = 3
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  opcode_t             s_opcode,
    output logic                s_ready,
    input  logic                negative,
    output logic [PIDX_W-1:0]   plane,
    output fct_mac_ctrl_t       ctrl,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                inside_res,
    output logic [FAIL_W-1:0]   failing
);

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PIDX_W-1:0]   plane_reg, plane_next;
    logic                m_valid_reg, m_valid_next;
    logic                inside_reg, inside_next;
    logic [FAIL_W-1:0]   fail_reg, fail_next;
    logic                last_plane, out_free;

    assign last_plane = (plane_reg == PIDX_W'(NUM_PLANES - 1));
    assign out_free   = !m_valid_reg || m_ready;

    // State, counters and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            plane_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            plane_reg   <= plane_next;
            m_valid_reg <= m_valid_next;
        end
        inside_reg <= inside_next;
        fail_reg   <= fail_next;
    end

    // Next state and unit control.
    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        plane_next     = plane_reg;
        inside_next    = inside_reg;
        fail_next      = fail_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        s_ready        = 1'b0;
        ctrl.capture   = 1'b0;
        ctrl.load_bias = 1'b0;
        ctrl.acc_en    = 1'b0;
        ctrl.mul_en    = 1'b0;
        ctrl.axis      = step_reg[2:1];
        ctrl.hi_half   = step_reg[0];

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                // Plane writes are handled at the store; only tests start a run.
                if (s_valid && s_opcode != OP_WRITE) begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_RUN;
                    step_next    = '0;
                    plane_next   = '0;
                end
            end
            ST_RUN: begin
                ctrl.load_bias = (step_reg == '0);
                ctrl.acc_en    = (step_reg != '0) && (step_reg != LAST_STEP);
                ctrl.mul_en    = (step_reg != LAST_STEP);
                if (step_reg != LAST_STEP) begin
                    step_next = step_reg + 1'b1;
                end else if (out_free) begin
                    // Decision step: the sum is complete, waits while the result is held.
                    if (negative) begin
                        inside_next  = 1'b0;
                        fail_next    = FAIL_W'(plane_reg);
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end else if (last_plane) begin
                        inside_next  = 1'b1;
                        fail_next    = FAIL_W'(NUM_PLANES);
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        plane_next = plane_reg + 1'b1;
                        step_next  = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign plane      = plane_reg;
    assign m_valid    = m_valid_reg;
    assign inside_res = inside_reg;
    assign failing    = fail_reg;

endmodule

@@ src/frustum_cull_tester.sv @@
// Frustum plane tester. Six (NUM_PLANES) planes of Q16.16 normal and offset are
// loaded one per transfer with opcode 0; a test transfer (point, sphere or
// axis-aligned box) is checked against the planes in index order and gives one
// result transfer with an inside flag and the first rejecting plane (NUM_PLANES,
// masked to three bits, when none rejects). Every plane must be written before
// the first test. A plane write leaves s_tready high. A test takes the planes in
// index order up to and including the first that rejects; for each plane the one
// shared multiplier forms six half-width partial products, then one closing
// accumulate and sign check decides. The block is ready for the next transfer as
// the result is issued. A finished result waits in the output register while the
// next item is taken; a test does not finish while the previous result is still
// held.
module frustum_cull_tester import fct_pkg::*; #(
    parameter int NUM_PLANES = 6,
    parameter int COORD_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // coord_x, coord_y, coord_z, far_x, far_y, far_z, scalar, zero fill
    input  logic [((7 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // opcode, plane_index
    input  logic [USER_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // inside_res, failing_plane, zero fill
    output logic [OUT_W-1:0]     m_tdata
);

    localparam int PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    opcode_t                      opcode;
    logic [INDEX_W-1:0]           plane_index;
    logic signed [COORD_BITS-1:0] coord_x, coord_y, coord_z;
    logic signed [COORD_BITS-1:0] far_x, far_y, far_z, scalar;
    logic signed [COORD_BITS-1:0] nx, ny, nz, offset;
    logic                         plane_wr, negative, inside_res;
    logic [PIDX_W-1:0]            plane;
    logic [FAIL_W-1:0]            failing;
    fct_mac_ctrl_t                ctrl;

    // Field unpacking.
    assign opcode      = opcode_t'(s_tuser[OPCODE_W-1:0]);
    assign plane_index = s_tuser[USER_W-1:OPCODE_W];
    assign coord_x     = $signed(s_tdata[0 * COORD_BITS +: COORD_BITS]);
    assign coord_y     = $signed(s_tdata[1 * COORD_BITS +: COORD_BITS]);
    assign coord_z     = $signed(s_tdata[2 * COORD_BITS +: COORD_BITS]);
    assign far_x       = $signed(s_tdata[3 * COORD_BITS +: COORD_BITS]);
    assign far_y       = $signed(s_tdata[4 * COORD_BITS +: COORD_BITS]);
    assign far_z       = $signed(s_tdata[5 * COORD_BITS +: COORD_BITS]);
    assign scalar      = $signed(s_tdata[6 * COORD_BITS +: COORD_BITS]);

    // A write to a plane beyond the table is dropped.
    assign plane_wr = s_tvalid && s_tready && (opcode == OP_WRITE)
                      && (int'(plane_index) < NUM_PLANES);

    fct_plane_store #(
        .NUM_PLANES (NUM_PLANES),
        .COORD_BITS (COORD_BITS),
        .PIDX_W     (PIDX_W)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (plane_wr),
        .wr_addr   (PIDX_W'(plane_index)),
        .wr_nx     (coord_x),
        .wr_ny     (coord_y),
        .wr_nz     (coord_z),
        .wr_offset (scalar),
        .rd_addr   (plane),
        .rd_nx     (nx),
        .rd_ny     (ny),
        .rd_nz     (nz),
        .rd_offset (offset)
    );

    fct_mac #(
        .COORD_BITS (COORD_BITS)
    ) u_mac (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .in_opcode (opcode),
        .in_x      (coord_x),
        .in_y      (coord_y),
        .in_z      (coord_z),
        .in_far_x  (far_x),
        .in_far_y  (far_y),
        .in_far_z  (far_z),
        .in_scalar (scalar),
        .nx        (nx),
        .ny        (ny),
        .nz        (nz),
        .offset    (offset),
        .negative  (negative)
    );

    fct_seq #(
        .NUM_PLANES (NUM_PLANES),
        .PIDX_W     (PIDX_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_opcode   (opcode),
        .s_ready    (s_tready),
        .negative   (negative),
        .plane      (plane),
        .ctrl       (ctrl),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .inside_res (inside_res),
        .failing    (failing)
    );

    // Result packing.
    assign m_tdata = OUT_W'({failing, inside_res});

endmodule

@@ src/fct_checker.sv @@
module fct_checker import fct_pkg::*; #(
    parameter int NUM_PLANES = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [USER_W-1:0] s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A test transfer makes the block busy in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[OPCODE_W-1:0] != OP_WRITE) |=> !s_tready)
        else $error("block still ready after a test was taken");

    // A plane write leaves the block ready.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[OPCODE_W-1:0] == OP_WRITE) |=> s_tready)
        else $error("block busy after a plane write");

    // A new result comes with the block ready again.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result issued while the block is still busy");

    // An inside result names no rejecting plane.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> (m_tdata[FAIL_W:1] == FAIL_W'(NUM_PLANES)))
        else $error("inside result with a rejecting plane");

endmodule

bind frustum_cull_tester fct_checker #(
    .NUM_PLANES (NUM_PLANES)
) u_fct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
